// ===== rtl/ctsc_pkg.sv =====
// Package for coordinate_to_servo_compare: widths, constants, register codes,
// the arctangent table and the result type. No dependencies.
package ctsc_pkg;

  localparam int COORD_BITS_DEF    = 12;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_LEN          = 24;

  localparam int OFFSET_W = 8;
  localparam int BASE_W   = 12;
  localparam int GAIN_W   = 16;
  localparam int FRAC_W   = 16;
  localparam int ATAN_W   = 17;
  localparam int ZW       = 19;
  localparam int CMP_W    = 13;
  localparam int OUT_DW   = 16;
  localparam int SCALE_W  = 28;

  localparam logic [SCALE_W-1:0] ANGLE_SCALE = 28'd125164540;
  localparam logic [CMP_W-1:0]   COMPARE_MAX = 13'd8191;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  localparam logic [2:0] REG_X_OFFSET = 3'd0;
  localparam logic [2:0] REG_Y_OFFSET = 3'd1;
  localparam logic [2:0] REG_BASELINE = 3'd2;
  localparam logic [2:0] REG_X_GAIN   = 3'd3;
  localparam logic [2:0] REG_Y_GAIN   = 3'd4;

  localparam logic [OFFSET_W-1:0] X_OFFSET_RST = 8'd28;
  localparam logic [OFFSET_W-1:0] Y_OFFSET_RST = 8'd30;
  localparam logic [BASE_W-1:0]   BASELINE_RST = 12'd1000;
  localparam logic [GAIN_W-1:0]   X_GAIN_RST   = 16'd6554;
  localparam logic [GAIN_W-1:0]   Y_GAIN_RST   = 16'd3932;

  typedef struct packed {
    logic [CMP_W-1:0] value;
    logic             clamped;
  } result_t;

  function automatic logic [ATAN_W-1:0] atan_q16(input int idx);
    logic [ATAN_W-1:0] t;
    case (idx)
      0:       t = 17'd51472;
      1:       t = 17'd30386;
      2:       t = 17'd16055;
      3:       t = 17'd8150;
      4:       t = 17'd4091;
      5:       t = 17'd2047;
      6:       t = 17'd1024;
      7:       t = 17'd512;
      8:       t = 17'd256;
      9:       t = 17'd128;
      10:      t = 17'd64;
      11:      t = 17'd32;
      12:      t = 17'd16;
      13:      t = 17'd8;
      14:      t = 17'd4;
      15:      t = 17'd2;
      16:      t = 17'd1;
      default: t = 17'd0;
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/coordinate_to_servo_compare.sv =====
// Coordinate to servo compare value: dual-lane pipelined CORDIC arctangent.
// Registers in order: input register, one register per CORDIC iteration, two scaling
// stages, output register. Throughput one word per cycle unless the output buffer stalls.
// Synchronous active-low reset empties the pipeline and restores register defaults.
// Depends on ctsc_pkg, ctsc_cordic_stage, ctsc_scale, ctsc_out_buf.
module coordinate_to_servo_compare #(
  parameter  int COORD_BITS    = ctsc_pkg::COORD_BITS_DEF,
  parameter  int CORDIC_STAGES = ctsc_pkg::CORDIC_STAGES_DEF,
  localparam int IN_DW         = ((COORD_BITS + 7) / 8) * 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [IN_DW-1:0]            in_tdata,   // distance
  input  logic [0:0]                  in_tuser,   // mode
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [ctsc_pkg::OUT_DW-1:0] out_tdata,  // compare_value
  output logic [0:0]                  out_tuser,  // clamped
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [ctsc_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [ctsc_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [ctsc_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);

  localparam int NS    = (CORDIC_STAGES > ctsc_pkg::ATAN_LEN) ? ctsc_pkg::ATAN_LEN
                                                              : CORDIC_STAGES;
  localparam int NUM_W = COORD_BITS + 1;
  localparam int MAXB  = (NUM_W > ctsc_pkg::BASE_W) ? NUM_W : ctsc_pkg::BASE_W;
  localparam int XW    = MAXB + ctsc_pkg::FRAC_W + 3;
  localparam int FW    = ctsc_pkg::FRAC_W;

  logic [ctsc_pkg::OFFSET_W-1:0] x_offset_r, y_offset_r;
  logic [ctsc_pkg::BASE_W-1:0]   baseline_r;
  logic [ctsc_pkg::GAIN_W-1:0]   x_gain_r, y_gain_r;
  logic                          cfg_wr;

  logic                          en;
  logic                          s0_v_r;
  logic [NUM_W-1:0]              s0_num_a_r, s0_num_a_nxt;
  logic [ctsc_pkg::OFFSET_W-1:0] s0_num_b_r, s0_off_nxt;
  logic [ctsc_pkg::BASE_W-1:0]   s0_base_r, s0_base_nxt;
  logic [COORD_BITS-1:0]         s0_dist_r, dist_in;
  logic [ctsc_pkg::GAIN_W-1:0]   s0_gain_r, s0_gain_nxt;

  logic                           cv    [0:NS];
  logic signed [XW-1:0]           cxa   [0:NS];
  logic signed [XW-1:0]           cya   [0:NS];
  logic signed [ctsc_pkg::ZW-1:0] cza   [0:NS];
  logic signed [XW-1:0]           cxb   [0:NS];
  logic signed [XW-1:0]           cyb   [0:NS];
  logic signed [ctsc_pkg::ZW-1:0] czb   [0:NS];
  logic [COORD_BITS-1:0]          cdist [0:NS];
  logic [ctsc_pkg::GAIN_W-1:0]    cgain [0:NS];

  logic              res_v;
  ctsc_pkg::result_t res, out_res;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_offset_r <= ctsc_pkg::X_OFFSET_RST;
      y_offset_r <= ctsc_pkg::Y_OFFSET_RST;
      baseline_r <= ctsc_pkg::BASELINE_RST;
      x_gain_r   <= ctsc_pkg::X_GAIN_RST;
      y_gain_r   <= ctsc_pkg::Y_GAIN_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[4:2])
        ctsc_pkg::REG_X_OFFSET: x_offset_r <= cfg_pwdata[ctsc_pkg::OFFSET_W-1:0];
        ctsc_pkg::REG_Y_OFFSET: y_offset_r <= cfg_pwdata[ctsc_pkg::OFFSET_W-1:0];
        ctsc_pkg::REG_BASELINE: baseline_r <= cfg_pwdata[ctsc_pkg::BASE_W-1:0];
        ctsc_pkg::REG_X_GAIN:   x_gain_r   <= cfg_pwdata[ctsc_pkg::GAIN_W-1:0];
        ctsc_pkg::REG_Y_GAIN:   y_gain_r   <= cfg_pwdata[ctsc_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[4:2])
      ctsc_pkg::REG_X_OFFSET: cfg_prdata = ctsc_pkg::CFG_DW'(x_offset_r);
      ctsc_pkg::REG_Y_OFFSET: cfg_prdata = ctsc_pkg::CFG_DW'(y_offset_r);
      ctsc_pkg::REG_BASELINE: cfg_prdata = ctsc_pkg::CFG_DW'(baseline_r);
      ctsc_pkg::REG_X_GAIN:   cfg_prdata = ctsc_pkg::CFG_DW'(x_gain_r);
      ctsc_pkg::REG_Y_GAIN:   cfg_prdata = ctsc_pkg::CFG_DW'(y_gain_r);
      default:                cfg_prdata = '0;
    endcase
  end

  // input stage
  assign in_tready = en;
  assign dist_in   = in_tdata[COORD_BITS-1:0];

  always_comb begin
    s0_off_nxt   = in_tuser[0] ? y_offset_r : x_offset_r;
    s0_gain_nxt  = in_tuser[0] ? y_gain_r : x_gain_r;
    s0_num_a_nxt = NUM_W'(dist_in) + NUM_W'(s0_off_nxt);
    s0_base_nxt  = (baseline_r == '0) ? ctsc_pkg::BASE_W'(1) : baseline_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_num_a_r <= s0_num_a_nxt;
      s0_num_b_r <= s0_off_nxt;
      s0_base_r  <= s0_base_nxt;
      s0_dist_r  <= dist_in;
      s0_gain_r  <= s0_gain_nxt;
    end
  end

  assign cv[0]    = s0_v_r;
  assign cxa[0]   = $signed({{(XW-ctsc_pkg::BASE_W-FW){1'b0}}, s0_base_r, {FW{1'b0}}});
  assign cya[0]   = $signed({{(XW-NUM_W-FW){1'b0}}, s0_num_a_r, {FW{1'b0}}});
  assign cza[0]   = '0;
  assign cxb[0]   = cxa[0];
  assign cyb[0]   = $signed({{(XW-ctsc_pkg::OFFSET_W-FW){1'b0}}, s0_num_b_r, {FW{1'b0}}});
  assign czb[0]   = '0;
  assign cdist[0] = s0_dist_r;
  assign cgain[0] = s0_gain_r;

  for (genvar g = 0; g < NS; g++) begin : g_cordic
    ctsc_cordic_stage #(
      .XW    (XW),
      .DW    (COORD_BITS),
      .STAGE (g)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_v    (cv[g]),
      .xa      (cxa[g]),
      .ya      (cya[g]),
      .za      (cza[g]),
      .xb      (cxb[g]),
      .yb      (cyb[g]),
      .zb      (czb[g]),
      .coord   (cdist[g]),
      .gain    (cgain[g]),
      .v_r     (cv[g+1]),
      .xa_r    (cxa[g+1]),
      .ya_r    (cya[g+1]),
      .za_r    (cza[g+1]),
      .xb_r    (cxb[g+1]),
      .yb_r    (cyb[g+1]),
      .zb_r    (czb[g+1]),
      .coord_r (cdist[g+1]),
      .gain_r  (cgain[g+1])
    );
  end

  ctsc_scale #(
    .DW (COORD_BITS)
  ) u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (cv[NS]),
    .za    (cza[NS]),
    .zb    (czb[NS]),
    .coord (cdist[NS]),
    .gain  (cgain[NS]),
    .res_v (res_v),
    .res   (res)
  );

  ctsc_out_buf u_out_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_v    (res_v),
    .in_res  (res),
    .en      (en),
    .out_v   (out_tvalid),
    .out_rdy (out_tready),
    .out_res (out_res)
  );

  assign out_tdata = {{(ctsc_pkg::OUT_DW-ctsc_pkg::CMP_W){1'b0}}, out_res.value};
  assign out_tuser = out_res.clamped;

endmodule

// ===== rtl/ctsc_cordic_stage.sv =====
// One registered vectoring CORDIC iteration for both arctangent lanes.
// Carries the coordinate and gain alongside. Depends on ctsc_pkg.
module ctsc_cordic_stage #(
  parameter int XW    = 32,
  parameter int DW    = 12,
  parameter int STAGE = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_v,
  input  logic signed [XW-1:0]         xa,
  input  logic signed [XW-1:0]         ya,
  input  logic signed [ctsc_pkg::ZW-1:0] za,
  input  logic signed [XW-1:0]         xb,
  input  logic signed [XW-1:0]         yb,
  input  logic signed [ctsc_pkg::ZW-1:0] zb,
  input  logic [DW-1:0]                coord,
  input  logic [ctsc_pkg::GAIN_W-1:0]  gain,
  output logic                         v_r,
  output logic signed [XW-1:0]         xa_r,
  output logic signed [XW-1:0]         ya_r,
  output logic signed [ctsc_pkg::ZW-1:0] za_r,
  output logic signed [XW-1:0]         xb_r,
  output logic signed [XW-1:0]         yb_r,
  output logic signed [ctsc_pkg::ZW-1:0] zb_r,
  output logic [DW-1:0]                coord_r,
  output logic [ctsc_pkg::GAIN_W-1:0]  gain_r
);

  localparam logic signed [ctsc_pkg::ZW-1:0] ANG =
    ctsc_pkg::ZW'(ctsc_pkg::atan_q16(STAGE));

  logic signed [XW-1:0]           xa_nxt, ya_nxt, xb_nxt, yb_nxt;
  logic signed [ctsc_pkg::ZW-1:0] za_nxt, zb_nxt;

  always_comb begin
    if (ya > 0) begin
      xa_nxt = xa + (ya >>> STAGE);
      ya_nxt = ya - (xa >>> STAGE);
      za_nxt = za + ANG;
    end else begin
      xa_nxt = xa - (ya >>> STAGE);
      ya_nxt = ya + (xa >>> STAGE);
      za_nxt = za - ANG;
    end
    if (yb > 0) begin
      xb_nxt = xb + (yb >>> STAGE);
      yb_nxt = yb - (xb >>> STAGE);
      zb_nxt = zb + ANG;
    end else begin
      xb_nxt = xb - (yb >>> STAGE);
      yb_nxt = yb + (xb >>> STAGE);
      zb_nxt = zb - ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xa_r    <= xa_nxt;
      ya_r    <= ya_nxt;
      za_r    <= za_nxt;
      xb_r    <= xb_nxt;
      yb_r    <= yb_nxt;
      zb_r    <= zb_nxt;
      coord_r <= coord;
      gain_r  <= gain;
    end
  end

endmodule

// ===== rtl/ctsc_scale.sv =====
// Angle difference, count scaling, gain correction, rounding and clamp.
// Two register stages then the final result logic. Depends on ctsc_pkg.
module ctsc_scale #(
  parameter int DW = 12
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_v,
  input  logic signed [ctsc_pkg::ZW-1:0] za,
  input  logic signed [ctsc_pkg::ZW-1:0] zb,
  input  logic [DW-1:0]                  coord,
  input  logic [ctsc_pkg::GAIN_W-1:0]    gain,
  output logic                           res_v,
  output ctsc_pkg::result_t              res
);

  localparam int AW  = ctsc_pkg::ZW + 1;
  localparam int DGW = DW + ctsc_pkg::GAIN_W;
  localparam int PW  = AW + ctsc_pkg::SCALE_W;
  localparam int CW  = PW - ctsc_pkg::FRAC_W;
  localparam int RW  = ((CW > DGW) ? CW : DGW) + 2;
  localparam int QW  = RW - ctsc_pkg::FRAC_W;

  localparam logic signed [ctsc_pkg::SCALE_W-1:0] SCALE_S = ctsc_pkg::ANGLE_SCALE;
  localparam logic signed [RW-1:0] HALF = RW'(1) <<< (ctsc_pkg::FRAC_W - 1);

  logic                  a_v_r, b_v_r;
  logic signed [AW-1:0]  ang_r;
  logic [DGW-1:0]        dga_r, dgb_r;
  logic signed [PW-1:0]  prod_r;

  logic signed [RW-1:0]  res_full;
  logic signed [RW-1:0]  rnd;
  logic [QW-1:0]         q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_v;
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang_r  <= AW'(za) - AW'(zb);
      dga_r  <= DGW'(coord) * DGW'(gain);
      prod_r <= PW'(ang_r) * PW'(SCALE_S);
      dgb_r  <= dga_r;
    end
  end

  always_comb begin
    res_full = {{(RW-CW){prod_r[PW-1]}}, prod_r[PW-1:ctsc_pkg::FRAC_W]}
             - {{(RW-DGW){1'b0}}, dgb_r};
    rnd      = res_full + HALF;
    q        = rnd[RW-1:ctsc_pkg::FRAC_W];
    if (res_full[RW-1]) begin
      res.value   = '0;
      res.clamped = 1'b1;
    end else if (q > QW'(ctsc_pkg::COMPARE_MAX)) begin
      res.value   = ctsc_pkg::COMPARE_MAX;
      res.clamped = 1'b0;
    end else begin
      res.value   = q[ctsc_pkg::CMP_W-1:0];
      res.clamped = 1'b0;
    end
  end

  assign res_v = b_v_r;

endmodule

// ===== rtl/ctsc_out_buf.sv =====
// Output register with a skid entry; stalls the pipeline only when both are full.
// Depends on ctsc_pkg.
module ctsc_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_v,
  input  ctsc_pkg::result_t in_res,
  output logic              en,
  output logic              out_v,
  input  logic              out_rdy,
  output ctsc_pkg::result_t out_res
);

  logic              out_v_r, skid_v_r;
  ctsc_pkg::result_t out_r, skid_r;

  assign en      = !skid_v_r;
  assign out_v   = out_v_r;
  assign out_res = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (in_v && en) begin
      if (!out_v_r || out_rdy) begin
        out_v_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end else if (skid_v_r && out_rdy) begin
      skid_v_r <= 1'b0;
    end else if (out_rdy) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_v && en) begin
      if (!out_v_r || out_rdy) begin
        out_r <= in_res;
      end else begin
        skid_r <= in_res;
      end
    end else if (skid_v_r && out_rdy) begin
      out_r <= skid_r;
    end
  end

  a_skid_has_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry held without output word");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_rdy))
    else $error("skid entry filled without output stall");

  a_clamp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.clamped) |-> (out_r.value == '0))
    else $error("clamped word with nonzero value");

endmodule

// ===== sim/tb.sv =====
// Testbench for coordinate_to_servo_compare: streams coordinates through the block and
// checks each compare value against an arctangent predictor kept in a scoreboard class.
// Depends on ctsc_pkg and the block's RTL.
module tb;

  localparam int    STAGES          = ctsc_pkg::CORDIC_STAGES_DEF;
  localparam longint COUNTS_PER_PI  = 125164540;
  localparam int    LATENCY_WAIT    = 30;
  localparam int    PHASES          = 6;
  localparam int    WORDS_PER_PHASE = 215;
  localparam int    PRESSURE_PHASE  = 4;

  class servo_scoreboard;
    logic [ctsc_pkg::OFFSET_W-1:0] offset_x, offset_y;
    logic [ctsc_pkg::BASE_W-1:0]   base;
    logic [ctsc_pkg::GAIN_W-1:0]   gain_x, gain_y;
    ctsc_pkg::result_t             expected_q[$];
    longint                        atan_tab[24];
    int                            errors, checked, clamps;

    function new();
      for (int i = 0; i < 24; i++) begin
        atan_tab[i] = $rtoi($atan(1.0 / (2.0 ** i)) * 65536.0 + 0.5);
      end
      offset_x = ctsc_pkg::X_OFFSET_RST;
      offset_y = ctsc_pkg::Y_OFFSET_RST;
      base     = ctsc_pkg::BASELINE_RST;
      gain_x   = ctsc_pkg::X_GAIN_RST;
      gain_y   = ctsc_pkg::Y_GAIN_RST;
      errors   = 0;
      checked  = 0;
      clamps   = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        ctsc_pkg::REG_X_OFFSET: offset_x = value[ctsc_pkg::OFFSET_W-1:0];
        ctsc_pkg::REG_Y_OFFSET: offset_y = value[ctsc_pkg::OFFSET_W-1:0];
        ctsc_pkg::REG_BASELINE: base     = value[ctsc_pkg::BASE_W-1:0];
        ctsc_pkg::REG_X_GAIN:   gain_x   = value[ctsc_pkg::GAIN_W-1:0];
        ctsc_pkg::REG_Y_GAIN:   gain_y   = value[ctsc_pkg::GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    function longint vector_angle(longint num, longint den);
      longint x, y, z, xs, ys;
      x = den <<< 16;
      y = num <<< 16;
      z = 0;
      for (int i = 0; i < STAGES && i < 24; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys;
          y = y - xs;
          z = z + atan_tab[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - atan_tab[i];
        end
      end
      return z;
    endfunction

    function void note_input(logic mode, logic [11:0] coord);
      longint            d, off, gain, b, ang, counts, res, r;
      ctsc_pkg::result_t e;
      d      = coord;
      off    = mode ? offset_y : offset_x;
      gain   = mode ? gain_y : gain_x;
      b      = (base == 0) ? 1 : base;
      ang    = vector_angle(d + off, b) - vector_angle(off, b);
      counts = (ang * COUNTS_PER_PI) >>> 16;
      res    = counts - d * gain;
      if (res < 0) begin
        e.value   = '0;
        e.clamped = 1'b1;
        clamps++;
      end else begin
        r = (res + 32768) >>> 16;
        if (r > 8191) r = 8191;
        e.value   = r[ctsc_pkg::CMP_W-1:0];
        e.clamped = 1'b0;
      end
      expected_q.push_back(e);
    endfunction

    function void check_result(logic [ctsc_pkg::OUT_DW-1:0] data, logic [0:0] user);
      ctsc_pkg::result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word data=%0d clamped=%0d", $time, data, user);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (data !== {{(ctsc_pkg::OUT_DW-ctsc_pkg::CMP_W){1'b0}}, e.value}) begin
        $display("%0t: compare_value expected %0d actual %0d", $time, e.value, data);
        errors++;
      end
      if (user !== e.clamped) begin
        $display("%0t: clamped expected %0d actual %0d", $time, e.clamped, user);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_tvalid = 1'b0;
  logic                        in_tready;
  logic [15:0]                 in_tdata = '0;   // distance
  logic [0:0]                  in_tuser = '0;   // mode
  logic                        out_tvalid;
  logic                        out_tready = 1'b0;
  logic [ctsc_pkg::OUT_DW-1:0] out_tdata;       // compare_value
  logic [0:0]                  out_tuser;       // clamped
  logic                        cfg_psel = 1'b0;
  logic                        cfg_penable = 1'b0;
  logic                        cfg_pwrite = 1'b0;
  logic [ctsc_pkg::CFG_AW-1:0] cfg_paddr = '0;
  logic [ctsc_pkg::CFG_DW-1:0] cfg_pwdata = '0;
  logic [ctsc_pkg::CFG_DW-1:0] cfg_prdata;
  logic                        cfg_pready;

  servo_scoreboard sb;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int words_sent = 0;

  coordinate_to_servo_compare dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.set_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic write_all(input int xo, input int yo, input int bl, input int xg,
                           input int yg);
    write_reg(ctsc_pkg::REG_X_OFFSET, xo);
    write_reg(ctsc_pkg::REG_Y_OFFSET, yo);
    write_reg(ctsc_pkg::REG_BASELINE, bl);
    write_reg(ctsc_pkg::REG_X_GAIN, xg);
    write_reg(ctsc_pkg::REG_Y_GAIN, yg);
  endtask

  task automatic send_word(input logic mode, input logic [11:0] coord);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, coord};
    in_tuser  <= mode;
    do @(posedge clk); while (!in_tready);
    sb.note_input(mode, coord);
    words_sent++;
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY_WAIT) @(posedge clk);
  endtask

  initial begin
    logic [11:0] edge_dist[6];
    int          send_pcts[PHASES];
    int          stall_pcts[PHASES];
    logic [11:0] d;

    edge_dist  = '{12'd0, 12'd1, 12'd2048, 12'h555, 12'hAAA, 12'hFFF};
    send_pcts  = '{0, 77, 0, 28, 0, 28};
    stall_pcts = '{0, 0, 77, 28, 0, 28};
    sb = new();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < 6; i++) begin
      send_word(1'b0, edge_dist[i]);
      send_word(1'b1, edge_dist[i]);
    end
    in_tvalid <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: write_all(0, 255, 4095, 0, 65535);
        1: write_all(255, 0, 1, 65535, 0);
        2: write_all($urandom_range(255), $urandom_range(255), 0,
                     $urandom_range(65535), $urandom_range(65535));
        3: write_all($urandom_range(255), $urandom_range(255), $urandom_range(4095, 1),
                     $urandom_range(65535), $urandom_range(65535));
        4: write_all(28, 30, 1000, 6554, 3932);
        default: write_all($urandom_range(255), $urandom_range(255), $urandom_range(64, 1),
                           $urandom_range(65535), $urandom_range(65535));
      endcase
      send_idle_pct = send_pcts[p];
      stall_pct     = stall_pcts[p];
      if (p == PRESSURE_PHASE) hold_left = 300;
      if (p == 0) begin
        for (int i = 0; i < 4; i++) begin
          send_word(1'b0, edge_dist[i * 5 / 3]);
          send_word(1'b1, edge_dist[i * 5 / 3]);
        end
      end
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if ($urandom_range(99) < 15) begin
          d = edge_dist[$urandom_range(5)];
        end else begin
          d = $urandom_range(4095);
        end
        send_word($urandom_range(1), d);
      end
      in_tvalid <= 1'b0;
    end

    drain();
    $display("Covered %0d words over %0d register settings with idle and stall mixes;",
             words_sent, PHASES + 1);
    $display("%0d results checked, %0d of them clamped to zero.", sb.checked, sb.clamps);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
